// File: rtl/dsf_pkg.sv
package dsf_pkg;

  localparam int PHASE_BITS_DEF = 32;
  localparam int TRIG_DEPTH_DEF = 1024;

  // Shared multiplier operand and product widths
  localparam int MW = 34;
  localparam int PW = 2 * MW;

  // Shared divider widths
  localparam int DIV_NW = 58;
  localparam int DIV_DW = 44;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [29:0] CUT_ADJ_Q30 = 30'd998579896;

  // Configuration register indexes
  localparam logic [2:0] REG_BASE_INCR = 3'd0;
  localparam logic [2:0] REG_HARMONICS = 3'd1;
  localparam logic [2:0] REG_CUTOFF    = 3'd2;
  localparam logic [2:0] REG_FM_ATTEN  = 3'd3;
  localparam logic [2:0] REG_MOD_EN    = 3'd4;
  localparam logic [2:0] REG_MIN_INCR  = 3'd5;

  function automatic longint mulq(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  // sin(pi/2 * t), t in Q30 within [0,1], odd series to t^9
  function automatic longint quarter_sine(longint t);
    longint t2;
    longint p;
    t2 = mulq(t, t);
    p = 64'sd172272;
    p = 64'sd5026995 - mulq(t2, p);
    p = 64'sd85569306 - mulq(t2, p);
    p = 64'sd693598668 - mulq(t2, p);
    p = 64'sd1686629713 - mulq(t2, p);
    p = mulq(t, p);
    if (p > 64'sd1073741824) p = 64'sd1073741824;
    if (p < 0) p = 0;
    return p;
  endfunction

  // One table entry, lg = log2 of the table depth
  function automatic logic signed [31:0] sine_entry(int k, int lg);
    longint u;
    longint q;
    longint r;
    longint s;
    u = longint'(k) << (32 - lg);
    q = (u >> 30) & 64'sd3;
    r = u & 64'sh3FFF_FFFF;
    s = quarter_sine(q[0] ? (64'sd1073741824 - r) : r);
    return 32'((q >= 2) ? -s : s);
  endfunction

endpackage

// File: rtl/dsf_bandlimited_saw_oscillator.sv
// Band-limited sawtooth oscillator (discrete summation formula), one output sample per
// input transfer. One shared 34x34 multiplier and one shared bit-serial divider do all the
// work under a sequencer, so the block takes one sample at a time; when bipolar FM is
// enabled with a negative fm_mod, the step takes an extra division. The output division
// and the shift-add for the harmonic phase make up most of the work per sample. After
// reset, and after every write of harmonics or cutoff_base, the gains are recomputed,
// and the input is stalled until that is done. A finished sample waits in an output
// register while the next one runs.
module dsf_bandlimited_saw_oscillator #(
  parameter int PHASE_BITS       = dsf_pkg::PHASE_BITS_DEF,
  parameter int TRIG_TABLE_DEPTH = dsf_pkg::TRIG_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               block_start_i,
  input  logic signed [15:0] cutoff_mod_i,
  input  logic signed [15:0] freq_mod_i,
  input  logic signed [15:0] fm_mod_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] sample_o
);

  localparam int PB = PHASE_BITS;
  localparam int L  = $clog2(TRIG_TABLE_DEPTH);
  localparam int MW = dsf_pkg::MW;
  localparam int PW = dsf_pkg::PW;
  localparam int NW = dsf_pkg::DIV_NW;
  localparam int DW = dsf_pkg::DIV_DW;

  localparam logic [30:0] ONE_Q30_W = dsf_pkg::ONE_Q30;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_S1     = 5'd1;
  localparam logic [4:0] ST_S2     = 5'd2;
  localparam logic [4:0] ST_FM1    = 5'd3;
  localparam logic [4:0] ST_FM2    = 5'd4;
  localparam logic [4:0] ST_FM3    = 5'd5;
  localparam logic [4:0] ST_FMDIV  = 5'd6;
  localparam logic [4:0] ST_CLAMP  = 5'd7;
  localparam logic [4:0] ST_P2     = 5'd8;
  localparam logic [4:0] ST_RA     = 5'd9;
  localparam logic [4:0] ST_RB     = 5'd10;
  localparam logic [4:0] ST_RC     = 5'd11;
  localparam logic [4:0] ST_M1     = 5'd12;
  localparam logic [4:0] ST_M2     = 5'd13;
  localparam logic [4:0] ST_M3     = 5'd14;
  localparam logic [4:0] ST_M4     = 5'd15;
  localparam logic [4:0] ST_M5     = 5'd16;
  localparam logic [4:0] ST_M6     = 5'd17;
  localparam logic [4:0] ST_M7     = 5'd18;
  localparam logic [4:0] ST_M8     = 5'd19;
  localparam logic [4:0] ST_M9     = 5'd20;
  localparam logic [4:0] ST_DEN    = 5'd21;
  localparam logic [4:0] ST_DSTART = 5'd22;
  localparam logic [4:0] ST_DWAIT  = 5'd23;
  localparam logic [4:0] ST_SC0    = 5'd24;
  localparam logic [4:0] ST_SC1    = 5'd25;
  localparam logic [4:0] ST_SC2    = 5'd26;
  localparam logic [4:0] ST_SC3    = 5'd27;
  localparam logic [4:0] ST_SC4    = 5'd28;
  localparam logic [4:0] ST_SC5    = 5'd29;
  localparam logic [4:0] ST_SC6    = 5'd30;

  // configuration
  logic [31:0] base_q;
  logic [7:0]  harm_q;
  logic [15:0] cutb_q, att_q, minp_q;
  logic [2:0]  men_q;
  logic        scale_req_q;

  logic [4:0]          state_q;
  logic [PB-1:0]       phase_q, p2_q, phase_step;
  logic [31:0]         held_q;
  logic [23:0]         scale0_q, scale1_q;
  logic [39:0]         incr_q;
  logic [15:0]         ratio_q;
  logic signed [15:0]  fm_q;
  logic [29:0]         fc_q, x_q, c_q;
  logic [30:0]         h_q;
  logic [7:0]          hcnt_q;
  logic [3:0]          cnt_q;
  logic signed [31:0]  sn_q, cs_q, s2_q, c2_q;
  logic signed [33:0]  fccs_q, u_q;
  logic signed [35:0]  num_q, den_q, den_d;
  logic signed [PW-1:0] prod_q;
  logic [23:0]         sample_q;
  logic                out_valid_q;

  logic signed [MW-1:0] ma, mb;
  logic signed [33:0]   q30;
  logic [29:0]          x_w;
  logic [16:0]          fm_mag;
  logic [19:0]          att10;
  logic [30:0]          fs1, fs2, d_w;
  logic [35:0]          num_mag;
  logic [31:0]          clamped;
  logic [39:0]          incr_acc;
  logic [8:0]           hmul;
  logic [L-1:0]         rom_addr;
  logic signed [31:0]   rom_rd;
  logic                 in_xfer, out_xfer, out_write;
  logic                 div_start, div_busy, div_done;
  logic [NW-1:0]        div_dividend, div_quo;
  logic [DW-1:0]        div_divisor;
  logic [23:0]          sat_val;

  assign in_stall_o  = (state_q != ST_IDLE) || scale_req_q;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign out_write   = (state_q == ST_DWAIT) && div_done && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  assign q30     = prod_q[63:30];
  assign x_w     = prod_q[36:7];
  assign fm_mag  = fm_q[15] ? (17'd0 - {fm_q[15], fm_q}) : {1'b0, fm_q};
  assign att10   = 20'({att_q, 3'b0}) + 20'({att_q, 1'b0});
  assign fs1     = {scale0_q, 7'b0};
  assign fs2     = {scale1_q, 7'b0};
  assign d_w     = ONE_Q30_W - 31'(c_q);
  assign num_mag = num_q[35] ? (36'd0 - num_q) : num_q;
  assign hmul    = 9'(harm_q) + 9'd2;

  generate
    if (PB >= 32) begin : g_step_wide
      assign phase_step = PB'(held_q) << (PB - 32);
    end else begin : g_step_narrow
      assign phase_step = PB'(held_q >> (32 - PB));
    end
  endgenerate

  always_comb begin
    if (incr_q < 40'(minp_q)) clamped = 32'(minp_q);
    else if (incr_q > 40'hFF_FFFF_FFFF >> 8) clamped = 32'hFFFF_FFFF;
    else clamped = incr_q[31:0];
  end

  always_comb begin
    den_d = 36'(ONE_Q30_W) - (36'(fccs_q) <<< 1) + 36'(q30);
    if (den_d < 36'sd1) den_d = 36'sd1;
  end

  // Saturate the quotient magnitude to the output range
  always_comb begin
    if (!num_q[35]) begin
      sat_val = (div_quo > NW'(24'h7F_FFFF)) ? 24'h7F_FFFF : div_quo[23:0];
    end else begin
      sat_val = (div_quo > NW'(24'h80_0000)) ? 24'h80_0000 : (24'd0 - div_quo[23:0]);
    end
  end

  // Operand selection for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      ST_S1:  begin ma = MW'(ratio_q); mb = MW'(dsf_pkg::CUT_ADJ_Q30); end
      ST_FM1: begin ma = MW'(fm_mag); mb = MW'(att10); end
      ST_FM2: begin ma = MW'(base_q); mb = MW'(x_w); end
      ST_M1:  begin ma = MW'(fc_q); mb = MW'(cs_q); end
      ST_M2:  begin ma = MW'(ONE_Q30_W) - q30; mb = MW'(fs1); end
      ST_M3:  begin ma = q30; mb = MW'(cs_q); end
      ST_M4:  begin ma = MW'(fs2); mb = MW'(c2_q); end
      ST_M5:  begin ma = MW'(fc_q); mb = MW'(sn_q); end
      ST_M6:  begin ma = MW'(fs2); mb = MW'(s2_q); end
      ST_M7:  begin ma = u_q; mb = q30; end
      ST_M8:  begin ma = MW'(fs1); mb = MW'(sn_q); end
      ST_M9:  begin ma = MW'(fc_q); mb = MW'(fc_q); end
      ST_SC0: begin ma = MW'(cutb_q); mb = MW'(dsf_pkg::CUT_ADJ_Q30); end
      ST_SC2: begin ma = MW'(h_q); mb = MW'(c_q); end
      ST_SC4: begin ma = MW'(d_w); mb = MW'(h_q); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    case (state_q)
      ST_S1:   rom_addr = phase_q[PB-1 -: L] + L'(TRIG_TABLE_DEPTH / 4);
      ST_RA:   rom_addr = p2_q[PB-1 -: L];
      ST_RB:   rom_addr = p2_q[PB-1 -: L] + L'(TRIG_TABLE_DEPTH / 4);
      default: rom_addr = phase_q[PB-1 -: L];
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = NW'({num_mag, 20'b0});
    div_divisor  = DW'(den_q);
    case (state_q)
      ST_FM3: begin
        div_start    = fm_q[15];
        div_dividend = NW'({base_q, 24'b0});
        div_divisor  = DW'(31'h100_0000 + 31'(x_q));
      end
      ST_DSTART: div_start = 1'b1;
      ST_SC4: begin
        div_start    = 1'b1;
        div_dividend = NW'({d_w, 23'b0});
        div_divisor  = DW'(ONE_Q30_W - h_q);
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
  end

  dsf_trig #(.DEPTH(TRIG_TABLE_DEPTH)) u_trig (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .rd_o   (rom_rd)
  );

  dsf_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'd4473924;
      harm_q <= 8'd50;
      cutb_q <= 16'hFFFF;
      att_q  <= 16'd0;
      men_q  <= 3'd0;
      minp_q <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dsf_pkg::REG_BASE_INCR: base_q <= cfg_wdata_i;
        dsf_pkg::REG_HARMONICS: harm_q <= cfg_wdata_i[7:0];
        dsf_pkg::REG_CUTOFF:    cutb_q <= cfg_wdata_i[15:0];
        dsf_pkg::REG_FM_ATTEN:  att_q  <= cfg_wdata_i[15:0];
        dsf_pkg::REG_MOD_EN:    men_q  <= cfg_wdata_i[2:0];
        dsf_pkg::REG_MIN_INCR:  minp_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scale_req_q <= 1'b1;
      out_valid_q <= 1'b0;
      phase_q     <= '0;
      held_q      <= 32'd4473924;
    end else begin
      if (out_write) out_valid_q <= 1'b1;
      else if (out_xfer) out_valid_q <= 1'b0;

      if (cfg_we_i && (cfg_idx_i == dsf_pkg::REG_HARMONICS ||
                       cfg_idx_i == dsf_pkg::REG_CUTOFF)) begin
        scale_req_q <= 1'b1;
      end else if (state_q == ST_IDLE && scale_req_q) begin
        scale_req_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (scale_req_q) state_q <= ST_SC0;
          else if (in_xfer) begin
            state_q <= ST_S1;
            if (block_start_i) held_q <= base_q;
          end
        end
        ST_S1: state_q <= ST_S2;
        ST_S2: state_q <= men_q[2] ? ST_FM1 : ST_CLAMP;
        ST_FM1: state_q <= ST_FM2;
        ST_FM2: state_q <= ST_FM3;
        ST_FM3: state_q <= fm_q[15] ? ST_FMDIV : ST_CLAMP;
        ST_FMDIV: if (div_done) state_q <= ST_CLAMP;
        ST_CLAMP: begin
          held_q  <= clamped;
          state_q <= ST_P2;
        end
        ST_P2: if (cnt_q == 4'd8) state_q <= ST_RA;
        ST_RA: state_q <= ST_RB;
        ST_RB: state_q <= ST_RC;
        ST_RC: state_q <= ST_M1;
        ST_M1: state_q <= ST_M2;
        ST_M2: state_q <= ST_M3;
        ST_M3: state_q <= ST_M4;
        ST_M4: state_q <= ST_M5;
        ST_M5: state_q <= ST_M6;
        ST_M6: state_q <= ST_M7;
        ST_M7: state_q <= ST_M8;
        ST_M8: state_q <= ST_M9;
        ST_M9: state_q <= ST_DEN;
        ST_DEN: state_q <= ST_DSTART;
        ST_DSTART: state_q <= ST_DWAIT;
        ST_DWAIT: begin
          if (out_write) begin
            phase_q <= phase_q + phase_step;
            state_q <= ST_IDLE;
          end
        end
        ST_SC0: state_q <= ST_SC1;
        ST_SC1: state_q <= ST_SC2;
        ST_SC2: state_q <= ST_SC3;
        ST_SC3: state_q <= (hcnt_q == harm_q) ? ST_SC4 : ST_SC2;
        ST_SC4: state_q <= ST_SC5;
        ST_SC5: state_q <= ST_SC6;
        ST_SC6: if (div_done) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    incr_acc = block_start_i ? 40'(base_q) : 40'(held_q);
    if (men_q[1] && !freq_mod_i[15] && freq_mod_i != 16'sd0) begin
      incr_acc = 40'({freq_mod_i[14:0], 16'b0});
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          incr_q  <= incr_acc;
          fm_q    <= fm_mod_i;
          ratio_q <= men_q[0] ? {~cutoff_mod_i[15], cutoff_mod_i[14:0]} : cutb_q;
        end
      end
      ST_S1: sn_q <= rom_rd;
      ST_S2: begin
        cs_q <= rom_rd;
        fc_q <= prod_q[45:16];
      end
      ST_FM2: x_q <= x_w;
      ST_FM3: begin
        if (fm_q == 16'sd0) incr_q <= 40'(base_q);
        else if (!fm_q[15]) incr_q <= 40'(base_q) + prod_q[63:24];
      end
      ST_FMDIV: if (div_done) incr_q <= div_quo[39:0];
      ST_CLAMP: begin
        p2_q  <= '0;
        cnt_q <= '0;
      end
      // harmonic phase: shift-add over the bits of harmonics+2
      ST_P2: begin
        if (hmul[cnt_q]) p2_q <= p2_q + (phase_q << cnt_q);
        cnt_q <= cnt_q + 4'd1;
      end
      ST_RB: s2_q <= rom_rd;
      ST_RC: c2_q <= rom_rd;
      ST_M2: fccs_q <= q30;
      ST_M4: num_q <= 36'(q30);
      ST_M5: num_q <= num_q - 36'(q30);
      ST_M6: u_q <= q30;
      ST_M8: num_q <= num_q - 36'(q30);
      ST_M9: num_q <= num_q - 36'(q30);
      ST_DEN: den_q <= den_d;
      ST_DWAIT: if (out_write) sample_q <= sat_val;
      ST_SC1: begin
        c_q    <= prod_q[45:16];
        h_q    <= ONE_Q30_W;
        hcnt_q <= '0;
      end
      ST_SC3: begin
        h_q    <= prod_q[60:30];
        hcnt_q <= hcnt_q + 8'd1;
      end
      ST_SC5: scale1_q <= prod_q[60:37];
      ST_SC6: if (div_done) scale0_q <= div_quo[23:0];
      default: ;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == ST_S1)
    else $error("accepted item did not start the sequence");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_out_from_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DWAIT))
    else $error("output written outside the final state");

  a_held_above_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLAMP |=> held_q >= 32'($past(minp_q)))
    else $error("held step below minimum");

endmodule

// File: rtl/dsf_div.sv
module dsf_div #(
  parameter int NW = dsf_pkg::DIV_NW,
  parameter int DW = dsf_pkg::DIV_DW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW-1:0] rem_q, dvs_q;
  logic [NW-1:0] quo_q;
  logic [DW:0]   shifted;
  logic          ge;

  assign shifted = {rem_q, quo_q[NW-1]};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // One quotient bit per cycle, restoring
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? DW'(shifted - {1'b0, dvs_q}) : shifted[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/dsf_trig.sv
module dsf_trig #(
  parameter int DEPTH = dsf_pkg::TRIG_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic [$clog2(DEPTH)-1:0]   addr_i,
  output logic signed [31:0]         rd_o
);

  localparam int L = $clog2(DEPTH);

  logic signed [31:0] tab_w [DEPTH];
  logic signed [31:0] rom_q;

  for (genvar k = 0; k < DEPTH; k++) begin : g_tab
    assign tab_w[k] = dsf_pkg::sine_entry(k, L);
  end

  always_ff @(posedge clk_i) begin
    rom_q <= tab_w[addr_i];
  end

  assign rd_o = rom_q;

endmodule
